// File: hw/rtl/jrq_pkg.sv
// Shared types and codes for the job ring queue.
// Holds opcodes, result status codes, register indexes and the
// command/status structs between controller and datapath.
package jrq_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] ST_GET_EMPTY   = 3'd0;
  localparam logic [2:0] ST_JOB         = 3'd1;
  localparam logic [2:0] ST_OVERFLOW    = 3'd2;
  localparam logic [2:0] ST_ADD_STORED  = 3'd3;
  localparam logic [2:0] ST_ADD_DROPPED = 3'd4;
  localparam logic [2:0] ST_CLEARED     = 3'd5;

  localparam logic REG_QUEUE_SIZE  = 1'b0;
  localparam logic REG_OVERFLOW_ID = 1'b1;

  localparam logic [4:0] QUEUE_SIZE_RESET  = 5'd16;
  localparam logic [7:0] OVERFLOW_ID_RESET = 8'hFF;
  localparam logic [7:0] LOST_SAT          = 8'hFF;

  localparam int ENTRY_W = 32;

  typedef struct packed {
    logic       add;
    logic       lose;
    logic       report;
    logic       pop_rd;
    logic       pop_wr;
    logic       clear;
    logic       load;
    logic [2:0] code;
  } cmd_t;

  typedef struct packed {
    logic size_zero;
    logic full;
    logic lost;
    logic empty;
  } stat_t;

endpackage

// File: hw/rtl/jrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/jrq_ctrl.sv
// Controller for the job ring queue: decodes requests into datapath commands.
// Depends on jrq_pkg.
module jrq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    op,
  input  jrq_pkg::stat_t stat,
  output jrq_pkg::cmd_t  cmd,
  output logic          busy,
  output logic          done
);

  typedef enum logic {S_IDLE, S_POP} state_t;

  state_t state;
  logic   accept;

  assign accept = start && (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.code = jrq_pkg::ST_GET_EMPTY;
    if (state == S_POP) begin
      cmd.pop_wr = 1'b1;
    end else if (accept) begin
      case (op)
        jrq_pkg::OP_ADD: begin
          cmd.load = 1'b1;
          if (stat.size_zero) begin
            cmd.code = jrq_pkg::ST_ADD_DROPPED;
          end else if (!stat.full) begin
            cmd.add  = 1'b1;
            cmd.code = jrq_pkg::ST_ADD_STORED;
          end else begin
            cmd.lose = 1'b1;
            cmd.code = jrq_pkg::ST_ADD_DROPPED;
          end
        end
        jrq_pkg::OP_GET: begin
          if (stat.lost) begin
            cmd.report = 1'b1;
          end else if (!stat.empty) begin
            cmd.pop_rd = 1'b1;
          end else begin
            cmd.load = 1'b1;
            cmd.code = jrq_pkg::ST_GET_EMPTY;
          end
        end
        jrq_pkg::OP_CLEAR: begin
          cmd.clear = 1'b1;
          cmd.load  = 1'b1;
          cmd.code  = jrq_pkg::ST_CLEARED;
        end
        default: begin
          cmd.load = 1'b1;
          cmd.code = jrq_pkg::ST_GET_EMPTY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.pop_rd) begin
            state <= S_POP;
            busy  <= 1'b1;
            done  <= 1'b0;
          end else begin
            done <= accept;
          end
        end
        S_POP: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/jrq_dp.sv
// Datapath for the job ring queue: indices, lost count, config and results.
// Depends on jrq_pkg and jrq_ram.
module jrq_dp #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  jrq_pkg::cmd_t  cmd,
  output jrq_pkg::stat_t stat,
  input  logic [7:0]     job_id,
  input  logic [7:0]     param_byte,
  input  logic [15:0]    param_word,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data,
  output logic [2:0]     status,
  output logic [7:0]     out_job_id,
  output logic [7:0]     out_param_byte,
  output logic [15:0]    out_param_word
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SZ_W  = ($clog2(DEPTH + 1) > 5) ? $clog2(DEPTH + 1) : 5;

  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] read_index;
  logic [7:0]       lost_count;
  logic [4:0]       queue_size;
  logic [7:0]       overflow_job_id;
  logic [SZ_W-1:0]  size;
  logic [IDX_W-1:0] write_index_next;
  logic [IDX_W-1:0] read_index_next;
  logic [jrq_pkg::ENTRY_W-1:0] rd_data;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [SZ_W-1:0] sz);
    logic [SZ_W:0] inc;
    inc = (SZ_W + 1)'(idx) + 1'b1;
    return (inc >= (SZ_W + 1)'(sz)) ? '0 : inc[IDX_W-1:0];
  endfunction

  always_comb begin
    if (SZ_W'(queue_size) > SZ_W'(DEPTH)) begin
      size = SZ_W'(DEPTH);
    end else begin
      size = SZ_W'(queue_size);
    end
  end

  assign write_index_next = advance(write_index, size);
  assign read_index_next  = advance(read_index, size);

  assign stat.size_zero = (size == '0);
  assign stat.full      = (lost_count != 8'd0);
  assign stat.lost      = (lost_count > 8'd1);
  assign stat.empty     = (lost_count == 8'd0) && (write_index == read_index);

  jrq_ram #(
    .WIDTH(jrq_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.add),
    .waddr(write_index),
    .wdata({job_id, param_byte, param_word}),
    .re   (cmd.pop_rd),
    .raddr(read_index),
    .q    (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index     <= '0;
      read_index      <= '0;
      lost_count      <= 8'd0;
      queue_size      <= jrq_pkg::QUEUE_SIZE_RESET;
      overflow_job_id <= jrq_pkg::OVERFLOW_ID_RESET;
    end else if (cfg_we) begin
      if (cfg_index == jrq_pkg::REG_QUEUE_SIZE) begin
        queue_size  <= cfg_data[4:0];
        write_index <= '0;
        read_index  <= '0;
        lost_count  <= 8'd0;
      end else begin
        overflow_job_id <= cfg_data;
      end
    end else begin
      if (cmd.add) begin
        write_index <= write_index_next;
        if (write_index_next == read_index) begin
          lost_count <= 8'd1;
        end
      end
      if (cmd.lose && (lost_count != jrq_pkg::LOST_SAT)) begin
        lost_count <= lost_count + 8'd1;
      end
      if (cmd.report) begin
        lost_count <= 8'd1;
      end
      if (cmd.pop_rd) begin
        read_index <= read_index_next;
        lost_count <= 8'd0;
      end
      if (cmd.clear) begin
        write_index <= '0;
        read_index  <= '0;
        lost_count  <= 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status         <= cmd.code;
      out_job_id     <= 8'd0;
      out_param_byte <= 8'd0;
      out_param_word <= 16'd0;
    end else if (cmd.report) begin
      status         <= jrq_pkg::ST_OVERFLOW;
      out_job_id     <= overflow_job_id;
      out_param_byte <= lost_count - 8'd1;
      out_param_word <= 16'd0;
    end else if (cmd.pop_wr) begin
      status         <= jrq_pkg::ST_JOB;
      out_job_id     <= rd_data[31:24];
      out_param_byte <= rd_data[23:16];
      out_param_word <= rd_data[15:0];
    end
  end

endmodule

// File: hw/rtl/job_ring_queue_with_overflow_count.sv
// Job ring queue with overflow count: top level, controller plus datapath.
// Result strobe done comes in the cycle after accept; a pop of a stored job first
// passes through state S_POP (registered RAM read) with busy high, then strobes.
// Throughput: one item per cycle while busy is low; a pop holds busy until done.
// Synchronous active-high reset empties the queue, sets queue_size 16 and
// overflow_job_id 255. The receiver cannot stall; each result strobes once.
module job_ring_queue_with_overflow_count #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [7:0]  job_id,
  input  logic [7:0]  param_byte,
  input  logic [15:0] param_word,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  out_job_id,
  output logic [7:0]  out_param_byte,
  output logic [15:0] out_param_word,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  jrq_pkg::cmd_t  cmd;
  jrq_pkg::stat_t stat;

  jrq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op   (op),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  jrq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .job_id        (job_id),
    .param_byte    (param_byte),
    .param_word    (param_word),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (status),
    .out_job_id    (out_job_id),
    .out_param_byte(out_param_byte),
    .out_param_word(out_param_word)
  );

endmodule
